FILE: hdl/vnt_pkg.sv
`timescale 1ns / 1ps
package vnt_pkg;
   localparam int FRAC_BITS_DEF = 16;
   localparam logic [2:0] OP_WRITE = 3'd0;
   localparam logic [2:0] OP_IDENT = 3'd1;
   localparam logic [2:0] OP_COFAC = 3'd2;
   localparam logic [2:0] OP_POINT = 3'd3;
   localparam logic [2:0] OP_NORM  = 3'd4;
   localparam logic [0:0] REG_EPS  = 1'd0;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        is_normal;
      logic        too_short;
      logic        saturated;
   } result_type;

   function automatic logic [31:0] sat32(input logic signed [65:0] v, inout logic f);
      logic [31:0] r;
      if (v > 66'sd2147483647) begin
         f = 1'b1; r = 32'h7fffffff;
      end else if (v < -66'sd2147483648) begin
         f = 1'b1; r = 32'h80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction
endpackage

FILE: hdl/vnt_lane.sv
`timescale 1ns / 1ps
// One product lane: a*b with floor shift, saturated, one register stage.
module vnt_lane #(
   parameter int FRAC_BITS = vnt_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] prod_ff,
   output logic        sat_ff
);
   import vnt_pkg::*;
   logic signed [63:0] p;
   logic signed [65:0] q;
   logic [31:0] prod_in;
   logic sat_in;
   always_comb begin
      p = $signed(a) * $signed(b);
      q = 66'(p >>> FRAC_BITS);
      sat_in = 1'b0;
      prod_in = sat32(q, sat_in);
   end
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sat_ff  <= sat_in;
   end
endmodule

FILE: hdl/vnt_divsqrt.sv
`timescale 1ns / 1ps
// Bit-serial floor square root, then, unless the length is within epsilon, three restoring divides.
module vnt_divsqrt #(
   parameter int FRAC_BITS = vnt_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] rx,
   input  logic [31:0] ry,
   input  logic [31:0] rz,
   input  logic [16:0] eps,
   output logic        done,
   output logic [31:0] ox,
   output logic [31:0] oy,
   output logic [31:0] oz,
   output logic        short_o
);
   localparam int NW = 32 + FRAC_BITS;
   localparam logic [2:0] S_IDLE = 3'd0, S_SQ = 3'd1, S_SQRT = 3'd2, S_CHK = 3'd3,
      S_DIV = 3'd4, S_DONE = 3'd5;
   logic [2:0] state_ff, state_in;
   logic [65:0] n_ff, n_in, r_ff, r_in, bit_ff, bit_in;
   logic [31:0] mag_ff [3];
   logic [31:0] mag_in [3];
   logic [31:0] raw_ff [3];
   logic [1:0] ci_ff, ci_in;
   logic [6:0] k_ff, k_in;
   logic [NW-1:0] q_ff, q_in;
   logic [33:0] rem_ff, rem_in;
   logic [31:0] res_ff [3];
   logic [31:0] res_in [3];
   logic short_ff, short_in;
   logic [33:0] trial;
   logic [NW-1:0] dvd;

   always_comb begin
      state_in = state_ff; n_in = n_ff; r_in = r_ff; bit_in = bit_ff;
      mag_in = mag_ff; ci_in = ci_ff; k_in = k_ff; q_in = q_ff; rem_in = rem_ff;
      res_in = res_ff; short_in = short_ff;
      dvd = {mag_ff[ci_ff], {FRAC_BITS{1'b0}}};
      trial = {rem_ff[32:0], dvd[k_ff[5:0]]};
      unique case (state_ff)
         S_IDLE: if (start) begin
            mag_in[0] = rx[31] ? 32'(-rx) : rx;
            mag_in[1] = ry[31] ? 32'(-ry) : ry;
            mag_in[2] = rz[31] ? 32'(-rz) : rz;
            state_in = S_SQ;
         end
         S_SQ: begin
            n_in = 66'(64'(mag_ff[0]) * 64'(mag_ff[0])) + 66'(64'(mag_ff[1]) * 64'(mag_ff[1]))
               + 66'(64'(mag_ff[2]) * 64'(mag_ff[2]));
            r_in = '0;
            bit_in = 66'd1 << 64;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            if (bit_ff == 0) begin
               state_in = S_CHK;
            end else begin
               if (n_ff >= r_ff + bit_ff) begin
                  n_in = n_ff - (r_ff + bit_ff);
                  r_in = (r_ff >> 1) + bit_ff;
               end else begin
                  r_in = r_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         S_CHK: begin
            if (r_ff <= 66'(eps)) begin
               short_in = 1'b1;
               res_in = raw_ff;
               state_in = S_DONE;
            end else begin
               short_in = 1'b0;
               ci_in = '0; k_in = 7'(NW - 1); q_in = '0; rem_in = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (trial >= 34'(r_ff)) begin
               rem_in = trial - 34'(r_ff);
               q_in = {q_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = trial;
               q_in = {q_ff[NW-2:0], 1'b0};
            end
            if (k_ff == 0) begin
               res_in[ci_ff] = raw_ff[ci_ff][31] ? 32'(-q_in) : q_in[31:0];
               rem_in = '0; q_in = '0; k_in = 7'(NW - 1);
               if (ci_ff == 2'd2) state_in = S_DONE;
               else ci_in = ci_ff + 2'd1;
            end else begin
               k_in = k_ff - 7'd1;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
      n_ff <= n_in; r_ff <= r_in; bit_ff <= bit_in; mag_ff <= mag_in; ci_ff <= ci_in;
      k_ff <= k_in; q_ff <= q_in; rem_ff <= rem_in; res_ff <= res_in; short_ff <= short_in;
      if (state_ff == S_IDLE && start) begin
         raw_ff[0] <= rx; raw_ff[1] <= ry; raw_ff[2] <= rz;
      end
   end

   assign done = (state_ff == S_DONE);
   assign ox = res_ff[0];
   assign oy = res_ff[1];
   assign oz = res_ff[2];
   assign short_o = short_ff;
endmodule

FILE: hdl/vertex_normal_transform.sv
`timescale 1ns / 1ps
// channel   ports                     direction
// request   req_tvalid/tready/tdata   in
// result    rsp_tvalid/tready/tdata   out
// config    csr_psel..csr_prdata      in/out
// One request at a time. Writes and identity complete on acceptance; cofactors take
// three product rounds, one to drain the lanes and one to store; a point result
// passes the product rounds, the sum and the output register; a normal also waits
// on the serial square root and, unless too short, the three divides.
// Synchronous active-high reset loads identity matrices and epsilon 1.
// A waiting result holds in the output register until rsp_tready; the next
// request is taken the cycle after.
module vertex_normal_transform #(
   parameter int FRAC_BITS = vnt_pkg::FRAC_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[2:0], elem_index[6:3], elem_value[38:7], in_x[70:39], in_y[102:71],
   // in_z[134:103], zero fill
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64], is_normal[96], too_short[97],
   // saturated[98], zero fill
   output logic [103:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import vnt_pkg::*;
   localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);
   localparam logic [2:0] S_IDLE = 3'd0, S_MUL = 3'd1, S_SUM = 3'd2, S_DS = 3'd3,
      S_OUT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [31:0] m_ff [16];
   logic [31:0] c_ff [9];
   logic [16:0] eps_ff;
   logic [2:0] op_ff;
   logic [31:0] v_ff [3];
   logic [1:0] rnd_ff;
   logic [31:0] la [3];
   logic [31:0] lb [3];
   logic [31:0] lp [3];
   logic [2:0] ls;
   logic [31:0] pr_ff [3][3];
   logic sat_ff;
   logic [31:0] acc [3];
   logic asat;
   logic ds_start, ds_done, ds_short;
   logic [31:0] dx, dy, dz;
   logic [31:0] ax_ff, ay_ff, az_ff;
   logic out_v_ff;
   result_type out_ff;
   logic [31:0] ox, oy, oz;
   localparam logic [3:0] CI [9][4] = '{
      '{4'd5, 4'd10, 4'd6, 4'd9}, '{4'd6, 4'd8, 4'd4, 4'd10}, '{4'd4, 4'd9, 4'd5, 4'd8},
      '{4'd9, 4'd2, 4'd10, 4'd1}, '{4'd10, 4'd0, 4'd8, 4'd2}, '{4'd8, 4'd1, 4'd9, 4'd0},
      '{4'd1, 4'd6, 4'd2, 4'd5}, '{4'd2, 4'd4, 4'd0, 4'd6}, '{4'd0, 4'd5, 4'd1, 4'd4}};

   // lanes: three product pairs per round
   logic [31:0] la2 [3];
   logic [31:0] lb2 [3];
   logic [31:0] lp2 [3];
   logic [2:0] ls2;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (op_ff == OP_COFAC) begin
            la[i] = m_ff[CI[rnd_ff*3+i][0]]; lb[i] = m_ff[CI[rnd_ff*3+i][1]];
            la2[i] = m_ff[CI[rnd_ff*3+i][2]]; lb2[i] = m_ff[CI[rnd_ff*3+i][3]];
         end else if (op_ff == OP_POINT) begin
            la[i] = v_ff[rnd_ff]; lb[i] = m_ff[rnd_ff*4+i];
            la2[i] = '0; lb2[i] = '0;
         end else begin
            la[i] = v_ff[rnd_ff]; lb[i] = c_ff[rnd_ff*3+i];
            la2[i] = '0; lb2[i] = '0;
         end
      end
   end
   for (genvar g = 0; g < 3; g++) begin : g_lane
      vnt_lane #(.FRAC_BITS(FRAC_BITS)) u_a (.clock(clock), .a(la[g]), .b(lb[g]),
         .prod_ff(lp[g]), .sat_ff(ls[g]));
      vnt_lane #(.FRAC_BITS(FRAC_BITS)) u_b (.clock(clock), .a(la2[g]), .b(lb2[g]),
         .prod_ff(lp2[g]), .sat_ff(ls2[g]));
   end

   // merge: sums of lane products in model order
   logic [1:0] prnd_ff;
   logic plive_ff;
   always_comb begin
      asat = 1'b0;
      for (int i = 0; i < 3; i++) acc[i] = '0;
      if (op_ff == OP_COFAC) begin
         for (int i = 0; i < 3; i++)
            acc[i] = sat32(66'($signed(lp[i])) - 66'($signed(lp2[i])), asat);
      end
      ox = '0; oy = '0; oz = '0;
      ox = sat32(66'($signed(pr_ff[0][0])) + 66'($signed(pr_ff[1][0])), asat);
      ox = sat32(66'($signed(ox)) + 66'($signed(pr_ff[2][0])), asat);
      oy = sat32(66'($signed(pr_ff[0][1])) + 66'($signed(pr_ff[1][1])), asat);
      oy = sat32(66'($signed(oy)) + 66'($signed(pr_ff[2][1])), asat);
      oz = sat32(66'($signed(pr_ff[0][2])) + 66'($signed(pr_ff[1][2])), asat);
      oz = sat32(66'($signed(oz)) + 66'($signed(pr_ff[2][2])), asat);
      if (op_ff == OP_POINT) begin
         ox = sat32(66'($signed(ox)) + 66'($signed(m_ff[12])), asat);
         oy = sat32(66'($signed(oy)) + 66'($signed(m_ff[13])), asat);
         oz = sat32(66'($signed(oz)) + 66'($signed(m_ff[14])), asat);
      end
   end

   logic [0:0] cfg_sel;
   logic cfg_wr;
   assign cfg_sel = csr_paddr[2];
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (cfg_sel == REG_EPS && csr_paddr[1:0] == 2'd0) ? 32'(eps_ff) : '0;

   assign req_tready = (state_ff == S_IDLE) && !out_v_ff;
   // the sums are registered in the sum cycle, so start once they are held
   assign ds_start = (state_ff == S_DS);

   vnt_divsqrt #(.FRAC_BITS(FRAC_BITS)) u_ds (.clock(clock), .reset(reset),
      .start(ds_start), .rx(ax_ff), .ry(ay_ff), .rz(az_ff), .eps(eps_ff), .done(ds_done),
      .ox(dx), .oy(dy), .oz(dz), .short_o(ds_short));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid && req_tready) begin
            if (req_tdata[2:0] == OP_COFAC || req_tdata[2:0] == OP_POINT ||
                req_tdata[2:0] == OP_NORM) state_in = S_MUL;
         end
         S_MUL: if (plive_ff && prnd_ff == 2'd2) state_in = S_SUM;
         S_SUM: begin
            if (op_ff == OP_COFAC) state_in = S_IDLE;
            else if (op_ff == OP_NORM) state_in = S_DS;
            else state_in = S_OUT;
         end
         S_DS: if (ds_done) state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         eps_ff <= 17'd1;
         out_v_ff <= 1'b0;
         for (int i = 0; i < 16; i++) m_ff[i] <= (i % 5 == 0) ? ONE : '0;
         for (int i = 0; i < 9; i++) c_ff[i] <= (i % 4 == 0) ? ONE : '0;
         rnd_ff <= '0; plive_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr && cfg_sel == REG_EPS && csr_paddr[1:0] == 2'd0) eps_ff <= csr_pwdata[16:0];
         if (rsp_tvalid && rsp_tready) out_v_ff <= 1'b0;
         if (state_ff == S_IDLE && req_tvalid && req_tready) begin
            op_ff <= req_tdata[2:0];
            v_ff[0] <= req_tdata[70:39]; v_ff[1] <= req_tdata[102:71];
            v_ff[2] <= req_tdata[134:103];
            rnd_ff <= '0; plive_ff <= 1'b0; sat_ff <= 1'b0;
            if (req_tdata[2:0] == OP_WRITE) m_ff[req_tdata[6:3]] <= req_tdata[38:7];
            if (req_tdata[2:0] == OP_IDENT)
               for (int i = 0; i < 16; i++) m_ff[i] <= (i % 5 == 0) ? ONE : '0;
         end
         if (state_ff == S_MUL) begin
            // lanes give products in the cycle after the round was issued
            prnd_ff <= rnd_ff; plive_ff <= 1'b1;
            if (rnd_ff != 2'd2) rnd_ff <= rnd_ff + 2'd1;
            if (plive_ff) begin
               for (int i = 0; i < 3; i++) pr_ff[prnd_ff][i] <= op_ff == OP_COFAC ? acc[i] : lp[i];
               if (op_ff != OP_COFAC) sat_ff <= sat_ff | (|ls) | (|ls2);
            end
         end
         if (state_ff == S_SUM) begin
            if (op_ff == OP_COFAC)
               for (int r = 0; r < 3; r++)
                  for (int i = 0; i < 3; i++) c_ff[r*3+i] <= pr_ff[r][i];
            ax_ff <= ox; ay_ff <= oy; az_ff <= oz;
            sat_ff <= sat_ff | asat;
         end
         if (state_ff == S_OUT) begin
            out_v_ff <= 1'b1;
            out_ff.is_normal <= (op_ff == OP_NORM);
            out_ff.saturated <= sat_ff;
            if (op_ff == OP_NORM) begin
               out_ff.x <= dx; out_ff.y <= dy; out_ff.z <= dz; out_ff.too_short <= ds_short;
            end else begin
               out_ff.x <= ax_ff; out_ff.y <= ay_ff; out_ff.z <= az_ff;
               out_ff.too_short <= 1'b0;
            end
         end
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata = {5'd0, out_ff.saturated, out_ff.too_short, out_ff.is_normal,
      out_ff.z, out_ff.y, out_ff.x};
endmodule

FILE: tb/vertex_normal_transform_test.sv
`timescale 1ns / 1ps
module vertex_normal_transform_test;
   import vnt_pkg::*;

   localparam int FB = FRAC_BITS_DEF;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [135:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   vertex_normal_transform dut (.*);

   always #4 clock = ~clock;

   // last field in the lowest bits, matching the request packing
   typedef struct packed {
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
      logic [31:0] val;
      logic [3:0]  idx;
      logic [2:0]  op;
   } vertex_req_t;

   // model state
   logic signed [31:0] mat [16];
   logic signed [31:0] cof [9];
   logic [16:0]        eps;

   vertex_req_t  pending_reqs [$];
   result_type   expected_results [$];
   int           error_count = 0;
   int           sent_count = 0;
   bit           hold_sender = 1'b0;
   int           long_stall = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   function automatic logic signed [31:0] clip(input logic signed [65:0] v,
                                               inout logic f);
      if (v > 66'sd2147483647) begin
         f = 1'b1; return 32'sh7fffffff;
      end
      if (v < -66'sd2147483648) begin
         f = 1'b1; return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // arithmetic shift floors, matching round toward minus infinity
   function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               inout logic f);
      logic signed [65:0] p;
      p = 66'(a) * 66'(b);
      return clip(p >>> FB, f);
   endfunction

   function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                               input logic signed [31:0] b,
                                               inout logic f);
      return clip(66'(a) + 66'(b), f);
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [65:0] n);
      logic [65:0] r, b;
      r = 0;
      b = 66'd1 << 64;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b; r = (r >> 1) + b;
         end else r >>= 1;
         b >>= 2;
      end
      return r[63:0];
   endfunction

   function automatic void identity_matrix();
      for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? 32'sd65536 : 32'sd0;
   endfunction

   function automatic void build_cofactors();
      int t [9][4] = '{'{5,10,6,9}, '{6,8,4,10}, '{4,9,5,8},
                       '{9,2,10,1}, '{10,0,8,2}, '{8,1,9,0},
                       '{1,6,2,5}, '{2,4,0,6}, '{0,5,1,4}};
      logic signed [31:0] p, q;
      logic f;
      f = 1'b0;
      for (int k = 0; k < 9; k++) begin
         p = qmul(mat[t[k][0]], mat[t[k][1]], f);
         q = qmul(mat[t[k][2]], mat[t[k][3]], f);
         cof[k] = clip(66'(p) - 66'(q), f);
      end
   endfunction

   function automatic void predict_transform(input vertex_req_t r);
      logic signed [31:0] v [3];
      logic signed [31:0] o [3];
      logic signed [31:0] s;
      logic [31:0] m;
      logic [65:0] ss;
      logic [63:0] len, q;
      logic f;
      result_type e;
      f = 1'b0;
      v[0] = r.x; v[1] = r.y; v[2] = r.z;
      e = '0;
      case (r.op)
         OP_WRITE: mat[r.idx] = r.val;
         OP_IDENT: identity_matrix();
         OP_COFAC: build_cofactors();
         OP_POINT, OP_NORM: begin
            for (int c = 0; c < 3; c++) begin
               if (r.op == OP_POINT) begin
                  s = qmul(v[0], mat[c], f);
                  s = qadd(s, qmul(v[1], mat[4+c], f), f);
                  s = qadd(s, qmul(v[2], mat[8+c], f), f);
                  o[c] = qadd(s, mat[12+c], f);
               end else begin
                  s = qmul(v[0], cof[c], f);
                  s = qadd(s, qmul(v[1], cof[3+c], f), f);
                  o[c] = qadd(s, qmul(v[2], cof[6+c], f), f);
               end
            end
            if (r.op == OP_NORM) begin
               e.is_normal = 1'b1;
               ss = 0;
               for (int c = 0; c < 3; c++) begin
                  m = o[c] < 0 ? -o[c] : o[c];
                  ss += 66'(m) * 66'(m);
               end
               len = floor_sqrt(ss);
               if (len > 64'(eps)) begin
                  for (int c = 0; c < 3; c++) begin
                     m = o[c] < 0 ? -o[c] : o[c];
                     q = (64'(m) << FB) / len;
                     o[c] = o[c] < 0 ? -q[31:0] : q[31:0];
                  end
               end else e.too_short = 1'b1;
            end
            e.x = o[0]; e.y = o[1]; e.z = o[2];
            e.saturated = f;
            expected_results.push_back(e);
         end
         default: ;
      endcase
   endfunction

   // driver: bursts with random gaps
   int gap = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_transform(req_tdata[134:0]);
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap > 0 || hold_sender || pending_reqs.size() == 0) begin
               req_tvalid <= 1'b0;
               if (gap > 0) gap <= gap - 1;
            end else begin
               vertex_req_t n;
               n = pending_reqs.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {1'b0, n.z, n.y, n.x, n.val, n.idx, n.op};
               if ($urandom_range(0, 9) == 0) gap <= $urandom_range(1, 12);
            end
         end
      end
   end

   // monitor with its own stall pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            result_type got, want;
            got.x = rsp_tdata[31:0];
            got.y = rsp_tdata[63:32];
            got.z = rsp_tdata[95:64];
            got.is_normal = rsp_tdata[96];
            got.too_short = rsp_tdata[97];
            got.saturated = rsp_tdata[98];
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", got.x, 0);
            end else begin
               want = expected_results.pop_front();
               if (got.x !== want.x) report_mismatch("out_x", got.x, want.x);
               if (got.y !== want.y) report_mismatch("out_y", got.y, want.y);
               if (got.z !== want.z) report_mismatch("out_z", got.z, want.z);
               if (got.is_normal !== want.is_normal)
                  report_mismatch("is_normal", got.is_normal, want.is_normal);
               if (got.too_short !== want.too_short)
                  report_mismatch("too_short", got.too_short, want.too_short);
               if (got.saturated !== want.saturated)
                  report_mismatch("saturated", got.saturated, want.saturated);
            end
         end
         stall_phase <= stall_phase + 1;
         if (long_stall > 0) begin
            long_stall <= long_stall - 1;
            rsp_tready <= 1'b0;
         end else if ((stall_phase / 64) % 3 == 2) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   task automatic csr_write(input logic [16:0] v);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= 3'(4 * REG_EPS); csr_pwdata <= 32'(v);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      eps = v;
   endtask

   task automatic quiesce();
      wait (pending_reqs.size() == 0 && !req_tvalid && expected_results.size() == 0);
      repeat (600) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_q();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         2: return 32'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
         default: return 32'($signed($urandom_range(0, 1 << (FB + 1))) - (1 << FB));
      endcase
   endfunction

   function automatic vertex_req_t make_req(input logic [2:0] op);
      vertex_req_t r;
      r.op = op; r.idx = 4'($urandom); r.val = rand_q();
      r.x = rand_q(); r.y = rand_q(); r.z = rand_q();
      return r;
   endfunction

   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++) begin
         int k;
         k = $urandom_range(0, 99);
         if (k < 25) pending_reqs.push_back(make_req(OP_WRITE));
         else if (k < 28) pending_reqs.push_back(make_req(OP_IDENT));
         else if (k < 36) pending_reqs.push_back(make_req(OP_COFAC));
         else if (k < 66) pending_reqs.push_back(make_req(OP_POINT));
         else if (k < 97) pending_reqs.push_back(make_req(OP_NORM));
         else pending_reqs.push_back(make_req(3'($urandom_range(5, 7))));
      end
   endtask

   initial begin
      vertex_req_t r;
      identity_matrix();
      for (int i = 0; i < 9; i++) cof[i] = (i % 4 == 0) ? 32'sd65536 : 32'sd0;
      eps = 1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: identity point, extremes, zero normal, unused opcodes
      r = make_req(OP_POINT); r.x = 32'h7fffffff; r.y = 32'h80000000; r.z = 0;
      pending_reqs.push_back(r);
      r = make_req(OP_NORM); r.x = 0; r.y = 0; r.z = 0;
      pending_reqs.push_back(r);
      r = make_req(OP_NORM); r.x = 32'h80000000; r.y = 32'h80000000; r.z = 32'h80000000;
      pending_reqs.push_back(r);
      for (int i = 0; i < 16; i++) begin
         r = make_req(OP_WRITE); r.idx = 4'(i);
         r.val = (i == 0) ? 32'h7fffffff : (i == 5) ? 32'h80000000 : rand_q();
         pending_reqs.push_back(r);
      end
      pending_reqs.push_back(make_req(OP_COFAC));
      pending_reqs.push_back(make_req(OP_NORM));
      pending_reqs.push_back(make_req(OP_POINT));
      pending_reqs.push_back(make_req(3'd5));
      pending_reqs.push_back(make_req(3'd7));
      pending_reqs.push_back(make_req(OP_IDENT));
      pending_reqs.push_back(make_req(OP_POINT));
      quiesce();

      // several epsilon settings, zero and 65536 included
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: csr_write(17'd0);
            1: csr_write(17'd65536);
            2: csr_write(17'($urandom_range(0, 65536)));
            3: csr_write(17'd1);
            default: csr_write(17'($urandom_range(0, 4096)));
         endcase
         if (ph == 1) long_stall = 400;
         queue_random(330);
         if (ph == 2) begin
            // let part of the burst go, drain fully, then resume
            repeat (2000) @(posedge clock);
            hold_sender = 1'b1;
            wait (!req_tvalid && expected_results.size() == 0);
            repeat (50) @(posedge clock);
            hold_sender = 1'b0;
         end
         quiesce();
      end

      if (error_count == 0) $display("vertex_normal_transform verification clean");
      else $display("vertex_normal_transform verification failed");
      $finish;
   end

   initial begin
      #40ms;
      $display("vertex_normal_transform verification failed");
      $finish;
   end
endmodule
